### hdl/pfba_pkg.sv
// Shared types and constants for the page frame bitmap allocator.
// No dependencies; imported by the datapath, the controller and the top level.
package pfba_pkg;

  // Default geometry of the page map
  localparam int MAX_PAGES_DEF    = 4096;
  localparam int PAGE_SHIFT_DEF   = 12;

  // Fixed field widths
  localparam int RUN_W            = 13;
  localparam int ADDR_W           = 32;
  localparam int POOL_PAGES_RESET = 4096;

  // Command codes carried in the input word's tuser
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Register select (byte address bit 2)
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_PAGES = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;       // clearing pass: write a zero word, advance
    logic load;      // capture the input word
    logic prep;      // set up scan or free range
    logic scan;      // first-fit search, one map word per cycle
    logic mark;      // read-modify-write of the run's words
    logic load_out;  // move the result into the output register
  } pfba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic zero_len;
    logic free_empty;
    logic found;
    logic fail;
    logic mark_done;
  } pfba_stat_t;

endpackage

### hdl/pfba_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pfba_datapath.sv
// Datapath of the allocator: page map RAM, word-at-a-time first-fit search,
// run marking/clearing and result registers. Depends on pfba_pkg, pfba_ram.
module pfba_datapath #(
  parameter int MAX_PAGES  = pfba_pkg::MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = pfba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfba_pkg::pfba_cmd_t               cmd_i,
  output pfba_pkg::pfba_stat_t              stat_o,
  input  logic                              in_cmd,
  input  logic [pfba_pkg::RUN_W-1:0]        in_run_length,
  input  logic [pfba_pkg::ADDR_W-1:0]       in_free_address,
  input  logic [pfba_pkg::ADDR_W-1:0]       pool_base,
  input  logic [pfba_pkg::RUN_W-1:0]        pool_pages,
  output logic [pfba_pkg::ADDR_W-1:0]       out_page_address,
  output logic                              out_ok
);
  import pfba_pkg::*;

  localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
  localparam int AW        = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
  localparam int CW        = $clog2(MAX_PAGES + 1);
  localparam int NW        = ((CW > RUN_W) ? CW : RUN_W) + 1;
  localparam int FW        = ADDR_W - PAGE_SHIFT;

  // Item and progress registers
  logic              cmd_r;
  logic [RUN_W-1:0]  len_r;
  logic [ADDR_W-1:0] faddr_r;
  logic [NW-1:0]     lo_r, hi_r;
  logic [NW-1:0]     run_r, rstart_r;
  logic [AW-1:0]     rd_w_r, pw_r;
  logic              pv_r;
  logic              res_ok_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_ok_r;

  // RAM interface
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       q;

  // Combinational datapath signals
  logic [NW-1:0]     lim;
  logic [ADDR_W-1:0] fdiff;
  logic [FW-1:0]     fidx;
  logic [NW-1:0]     fsum, free_lo, free_hi;
  logic              free_empty;
  logic [NW-1:0]     wbase, word_end;
  logic [31:0]       vm, f, g_acc, mmask, mark_word;
  logic [31:0]       h [6];
  logic [5:0]        off;
  logic [5:0]        tz, lead;
  logic [4:0]        int_s;
  logic [NW-1:0]     carry_tot, carry_start, found_start;
  logic              carry_hit, int_hit, len_small, hit, all_free, last_word;
  logic [NW-1:0]     run_nxt, rstart_nxt, hm1;
  logic [AW-1:0]     last_w;

  pfba_ram #(
    .WIDTH (32),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_w_r),
    .rdata (q)
  );

  // Effective pool size
  assign lim = (NW'(pool_pages) < NW'(MAX_PAGES)) ? NW'(pool_pages) : NW'(MAX_PAGES);

  // Free: address to page index, clipped to the pool
  assign fdiff      = faddr_r - pool_base;
  assign fidx       = fdiff[ADDR_W-1:PAGE_SHIFT];
  assign free_empty = (ADDR_W'(fidx) >= ADDR_W'(lim)) || (len_r == '0);
  assign free_lo    = NW'(fidx);
  assign fsum       = NW'(fidx) + NW'(len_r);
  assign free_hi    = (fsum < lim) ? fsum : lim;

  // Word being processed: pages past the pool count as used
  assign wbase    = NW'({pw_r, 5'b0});
  assign word_end = wbase + NW'(32);
  assign hm1      = hi_r - NW'(1);
  assign last_w   = hm1[AW+4:5];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      vm[i]    = (wbase + NW'(i)) < lim;
      mmask[i] = ((wbase + NW'(i)) >= lo_r) && ((wbase + NW'(i)) < hi_r);
    end
  end

  assign f = ~q & vm;

  // Free runs of len pages lying wholly inside the word (len up to 32)
  always_comb begin
    h[0] = f;
    for (int k = 0; k < 5; k++) begin
      h[k+1] = h[k] & (h[k] >> (1 << k));
    end
    g_acc = '1;
    off   = '0;
    for (int k = 0; k < 6; k++) begin
      if (len_r[k]) begin
        g_acc = g_acc & (h[k] >> off);
        off   = off + 6'(1 << k);
      end
    end
  end

  // Trailing free count, leading free count, lowest fitting start
  always_comb begin
    tz    = 6'd32;
    lead  = 6'd32;
    int_s = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!f[i]) tz = 6'(i);
      if (g_acc[i]) int_s = 5'(i);
    end
    for (int i = 0; i < 32; i++) begin
      if (!f[i]) lead = 6'(31 - i);
    end
  end

  // Search decision for the current word
  assign len_small   = (len_r <= RUN_W'(32));
  assign carry_tot   = run_r + NW'(tz);
  assign carry_hit   = carry_tot >= NW'(len_r);
  assign carry_start = (run_r != '0) ? rstart_r : wbase;
  assign int_hit     = len_small && (g_acc != '0);
  assign hit         = carry_hit || int_hit;
  assign found_start = carry_hit ? carry_start : (wbase + NW'(int_s));
  assign all_free    = &f;
  assign last_word   = word_end >= lim;
  assign run_nxt     = all_free ? (run_r + NW'(32)) : NW'(lead);
  assign rstart_nxt  = all_free ? carry_start : (word_end - NW'(lead));

  // Marking: set for allocate, clear for free
  assign mark_word = (cmd_r == CMD_FREE) ? (q & ~mmask) : (q | mmask);

  assign ram_we    = cmd_i.clr || (cmd_i.mark && pv_r);
  assign ram_waddr = cmd_i.clr ? rd_w_r : pw_r;
  assign ram_wdata = cmd_i.clr ? '0 : mark_word;

  // Status to controller
  assign stat_o.clr_last   = (rd_w_r == AW'(MAP_WORDS - 1));
  assign stat_o.is_alloc   = (cmd_r == CMD_ALLOC);
  assign stat_o.zero_len   = (len_r == '0);
  assign stat_o.free_empty = free_empty;
  assign stat_o.found      = pv_r && hit;
  assign stat_o.fail       = pv_r && !hit && last_word;
  assign stat_o.mark_done  = pv_r && (pw_r == last_w);

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_w_r   <= '0;
      pv_r     <= 1'b0;
      out_ok_r <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        rd_w_r <= rd_w_r + AW'(1);
      end
      if (cmd_i.load) begin
        cmd_r   <= in_cmd;
        len_r   <= in_run_length;
        faddr_r <= in_free_address;
      end
      if (cmd_i.prep) begin
        run_r      <= '0;
        rstart_r   <= '0;
        pv_r       <= 1'b0;
        res_ok_r   <= (cmd_r == CMD_FREE);
        res_addr_r <= '0;
        if (cmd_r == CMD_ALLOC) begin
          rd_w_r <= '0;
        end else begin
          lo_r   <= free_lo;
          hi_r   <= free_hi;
          rd_w_r <= free_lo[AW+4:5];
        end
      end
      if (cmd_i.scan) begin
        if (pv_r && hit) begin
          lo_r     <= found_start;
          hi_r     <= found_start + NW'(len_r);
          res_ok_r <= 1'b1;
          rd_w_r   <= found_start[AW+4:5];
          pv_r     <= 1'b0;
        end else begin
          rd_w_r <= rd_w_r + AW'(1);
          pw_r   <= rd_w_r;
          pv_r   <= 1'b1;
          if (pv_r) begin
            run_r    <= run_nxt;
            rstart_r <= rstart_nxt;
          end
        end
      end
      if (cmd_i.mark) begin
        rd_w_r <= rd_w_r + AW'(1);
        pw_r   <= rd_w_r;
        pv_r   <= 1'b1;
        if (cmd_r == CMD_ALLOC) begin
          res_addr_r <= pool_base + (ADDR_W'(lo_r) << PAGE_SHIFT);
        end
      end
      if (cmd_i.load_out) begin
        out_addr_r <= res_addr_r;
        out_ok_r   <= res_ok_r;
      end
    end
  end

  assign out_page_address = out_addr_r;
  assign out_ok           = out_ok_r;

`ifndef SYNTHESIS
  // Map writes stay inside the run's last word
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.mark && pv_r) |-> (pw_r <= last_w))
    else $error("map write past the end of the run");

  // A found run lies inside the pool
  a_found_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.scan && pv_r && hit) |-> ((found_start + NW'(len_r)) <= lim))
    else $error("found run extends past the pool");

  // Marking never runs on an empty range
  a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.mark |-> (lo_r < hi_r))
    else $error("marking an empty page range");
`endif

endmodule

### hdl/pfba_ctrl.sv
// Controller of the allocator: sequences clear, search, mark and result
// handoff, and owns the input/output handshakes. Depends on pfba_pkg.
module pfba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  pfba_pkg::pfba_stat_t stat_i,
  output pfba_pkg::pfba_cmd_t  cmd_o
);
  import pfba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        if (stat_i.is_alloc) begin
          state_nxt = stat_i.zero_len ? S_DONE : S_SCAN;
        end else begin
          state_nxt = stat_i.free_empty ? S_DONE : S_MARK;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.found) begin
          state_nxt = S_MARK;
        end else if (stat_i.fail) begin
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (stat_i.mark_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output register valid
  assign out_valid_nxt = cmd_o.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  // Finished item is handed off and the block returns to idle
  a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("result not handed to the output register");

  // An accepted word starts processing
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_PREP))
    else $error("accepted word not processed");

  // No result can exist during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result pending during map clear");
`endif

endmodule

### hdl/page_frame_bitmap_allocator_top.sv
// Page frame bitmap allocator, first fit: one bit per page of a pool.
// Input channel takes allocate/free words; output channel returns one result
// per word. Configuration via an APB-style port (pool_base at 0x0, pool_pages
// at 0x4). Items are processed one at a time; a new word is accepted while the
// previous result still waits in the output register.
// Sequence (W = words of 32 pages, MAX_PAGES/32, 128 by default):
//   allocate: accept, prepare, scan the map words until the run is found,
//   mark the words the run touches, then hand off the result; a zero length
//   skips scan and mark, and a scan that reaches the pool end without a fit
//   goes straight to the hand-off. The scan reads one map word per cycle
//   from the RAM port.
//   free: accept, prepare, mark, hand off; a range outside the pool skips marking.
// Reset: the map RAM is swept to all free, one word per cycle, over all W words;
// no input word is taken during that pass (configuration writes are).
// A stalled receiver holds the result in the output register; one further
// word may be accepted and processed, then the block waits to hand it off.
module page_frame_bitmap_allocator_top #(
  parameter int MAX_PAGES  = pfba_pkg::MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = pfba_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [12:0] run_length, [44:13] free_address, zeros
  input  logic [0:0]  in_tuser,    // [0] cmd
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] page_address
  output logic [0:0]  out_tuser,   // [0] ok
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pfba_pkg::*;

  logic [ADDR_W-1:0] pool_base_r;
  logic [RUN_W-1:0]  pool_pages_r;
  logic              cfg_wr;
  pfba_cmd_t         cmd;
  pfba_stat_t        stat;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      pool_pages_r <= RUN_W'(POOL_PAGES_RESET);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_POOL_BASE) begin
        pool_base_r <= cfg_pwdata;
      end else begin
        pool_pages_r <= cfg_pwdata[RUN_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_POOL_PAGES) ? {{(32-RUN_W){1'b0}}, pool_pages_r}
                                                       : pool_base_r;

  pfba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfba_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_cmd           (in_tuser[0]),
    .in_run_length    (in_tdata[12:0]),
    .in_free_address  (in_tdata[44:13]),
    .pool_base        (pool_base_r),
    .pool_pages       (pool_pages_r),
    .out_page_address (out_tdata),
    .out_ok           (out_tuser[0])
  );

endmodule

### test/tb_page_frame_bitmap_allocator_top.sv
// Self-checking testbench for page_frame_bitmap_allocator_top: first-fit page allocation
// and freeing on a bitmap, checked word by word against an in-bench map predictor.
// Depends on pfba_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module tb_page_frame_bitmap_allocator_top;
  import pfba_pkg::*;

  localparam int MAX_PAGES  = MAX_PAGES_DEF;
  localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;

  typedef struct {
    logic        cmd;
    logic [12:0] run_length;
    logic [31:0] free_address;
  } map_request_t;

  typedef struct {
    logic [31:0] page_address;
    logic        ok;
  } map_result_t;

  typedef struct {
    int unsigned first_page;
    int unsigned pages;
  } page_run_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // [12:0] run_length, [44:13] free_address, zeros
  logic [0:0]  in_tuser = '0;     // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] page_address
  logic [0:0]  out_tuser;         // [0] ok
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  page_frame_bitmap_allocator_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state: configuration and one bit per page (1 = used)
  logic [31:0]          pool_base_q = '0;
  logic [12:0]          pool_pages_q = 13'(POOL_PAGES_RESET);
  bit [MAX_PAGES-1:0]   page_used = '0;

  map_request_t request_q[$];
  map_result_t  result_q[$];
  page_run_t    held_runs[$];

  int   error_count = 0;
  bit   quiet_gaps = 1'b0;
  bit   in_fire = 1'b0;
  bit   out_fire = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  map_request_t drive_word;
  map_request_t seen_word;
  map_result_t  got_word;
  map_result_t  want_word;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return quiet_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int pool_limit();
    return (pool_pages_q < MAX_PAGES) ? int'(pool_pages_q) : MAX_PAGES;
  endfunction

  // First-fit allocate or free on the predicted map; returns the expected result
  task automatic predict_map_word(input map_request_t rq, output map_result_t res);
    int          lim;
    int          run;
    int          start;
    bit          found;
    logic [31:0] idx;
    longint      q;
    lim = pool_limit();
    res.page_address = '0;
    res.ok = 1'b0;
    run = 0;
    start = 0;
    found = 1'b0;
    if (rq.cmd == CMD_ALLOC) begin
      if (rq.run_length != 0) begin
        for (int p = 0; p < lim; p++) begin
          if (page_used[p]) begin
            run = 0;
          end else begin
            if (run == 0) start = p;
            run++;
            if (run == int'(rq.run_length)) begin
              found = 1'b1;
              break;
            end
          end
        end
      end
      if (found) begin
        for (int p = start; p < start + int'(rq.run_length); p++) page_used[p] = 1'b1;
        res.page_address = pool_base_q + (32'(start) << PAGE_SHIFT);
        res.ok = 1'b1;
        held_runs.push_back('{first_page: start, pages: rq.run_length});
      end
    end else begin
      // index wraps modulo 2^32; pages at or past the pool end are left alone
      idx = (rq.free_address - pool_base_q) >> PAGE_SHIFT;
      for (longint r = 0; r < longint'(rq.run_length); r++) begin
        q = longint'(idx) + r;
        if (q >= lim) break;
        page_used[q] = 1'b0;
      end
      res.ok = 1'b1;
    end
  endtask

  // Monitor: accepted words on both channels, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;
      if (out_fire) begin
        got_word.page_address = out_tdata;
        got_word.ok = out_tuser[0];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, actual addr %h ok %b",
                   $time, got_word.page_address, got_word.ok);
          error_count++;
        end else begin
          want_word = result_q.pop_front();
          if (got_word.page_address !== want_word.page_address) begin
            $display("%0t: page_address expected %h actual %h",
                     $time, want_word.page_address, got_word.page_address);
            error_count++;
          end
          if (got_word.ok !== want_word.ok) begin
            $display("%0t: ok expected %b actual %b", $time, want_word.ok, got_word.ok);
            error_count++;
          end
        end
        out_stall = draw_gap();
      end
      if (in_fire) begin
        seen_word.cmd = in_tuser[0];
        seen_word.run_length = in_tdata[12:0];
        seen_word.free_address = in_tdata[44:13];
        predict_map_word(seen_word, want_word);
        result_q.push_back(want_word);
      end
    end
  end

  // Input driver: one word at a time from the request queue, random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (request_q.size() > 0) begin
          drive_word = request_q.pop_front();
          in_tuser <= drive_word.cmd;
          in_tdata <= {3'b000, drive_word.free_address, drive_word.run_length};
          in_tvalid <= 1'b1;
          in_gap = draw_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: ready drops for a random stall after each accepted word
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_word(input logic cmd, input int unsigned len, input logic [31:0] addr);
    request_q.push_back('{cmd: cmd, run_length: 13'(len), free_address: addr});
  endtask

  // Wait until every word went through and every result came back
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (request_q.size() != 0 || in_tvalid || result_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic reg_write(input logic sel, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (sel == REG_POOL_BASE) pool_base_q = value;
    else pool_pages_q = value[12:0];
    want = (sel == REG_POOL_BASE) ? pool_base_q : {19'b0, pool_pages_q};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d read expected %h actual %h", $time, sel, want, cfg_prdata);
      error_count++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One random word: mostly allocations and frees of held runs, some noise
  task automatic queue_random_word();
    int          pick;
    int          k;
    int          len;
    int          lim;
    page_run_t   held;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    lim = pool_limit();
    if (pick < 80 && pick >= 45 && held_runs.size() == 0) pick = 0;
    if (pick < 45) begin
      k = $urandom_range(0, 99);
      if (k < 70) len = $urandom_range(1, 16);
      else if (k < 90) len = $urandom_range(1, 256);
      else if (k < 97) len = $urandom_range(1, 4096);
      else len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(4096, 8191);
      queue_word(CMD_ALLOC, len, $urandom);
    end else if (pick < 80) begin
      k = $urandom_range(0, held_runs.size() - 1);
      held = held_runs[k];
      held_runs.delete(k);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, held.pages) : held.pages;
      addr = pool_base_q + (32'(held.first_page) << PAGE_SHIFT)
             + 32'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
      queue_word(CMD_FREE, len, addr);
    end else if (pick < 95) begin
      addr = pool_base_q + (32'($urandom_range(0, lim + 8)) << PAGE_SHIFT)
             + 32'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
      queue_word(CMD_FREE, $urandom_range(0, 64), addr);
    end else begin
      queue_word(CMD_FREE, $urandom_range(0, 8191), $urandom);
    end
  endtask

  task automatic run_phase(input logic [31:0] base, input int unsigned pages, input int count);
    int n;
    wait_drained();
    reg_write(REG_POOL_BASE, base);
    reg_write(REG_POOL_PAGES, pages);
    while (count > 0) begin
      quiet_gaps = ($urandom_range(0, 3) == 0);
      n = (count < 24) ? count : 24;
      count -= n;
      repeat (n) queue_random_word();
      wait_drained();
    end
    quiet_gaps = 1'b0;
  endtask

  // Stimulus: reset, directed corner cases, then random phases
  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    reg_write(REG_POOL_BASE, 32'h0);
    reg_write(REG_POOL_PAGES, 4096);

    // zero length, base zero at page 0, full-pool run, no fit, oversize free
    queue_word(CMD_ALLOC, 0, 32'h0);
    queue_word(CMD_ALLOC, 1, 32'hFFFF_FFFF);
    queue_word(CMD_ALLOC, 4096, 32'h0);
    queue_word(CMD_FREE, 1, 32'h0000_0FFF);
    queue_word(CMD_ALLOC, 4096, 32'h0);
    queue_word(CMD_ALLOC, 1, 32'h0);
    queue_word(CMD_FREE, 8191, 32'h0);
    queue_word(CMD_FREE, 0, 32'hFFFF_FFFF);
    wait_drained();

    // pool larger than the map, address wrap, free below the base
    reg_write(REG_POOL_BASE, 32'hFFFF_F000);
    reg_write(REG_POOL_PAGES, 8191);
    queue_word(CMD_ALLOC, 2, 32'h0);
    queue_word(CMD_ALLOC, 1, 32'h0);
    queue_word(CMD_FREE, 1, 32'h0000_1FFF);
    queue_word(CMD_FREE, 5, 32'h1000_0000);
    queue_word(CMD_FREE, 3, 32'h7FFF_F000);
    queue_word(CMD_ALLOC, 3, 32'h0);
    wait_drained();

    // empty pool, then a one-page pool over a map that was not cleared
    reg_write(REG_POOL_BASE, 32'h1234_5000);
    reg_write(REG_POOL_PAGES, 0);
    queue_word(CMD_ALLOC, 1, 32'h0);
    queue_word(CMD_FREE, 1, 32'h1234_5000);
    wait_drained();
    reg_write(REG_POOL_PAGES, 1);
    queue_word(CMD_ALLOC, 1, 32'h0);
    queue_word(CMD_FREE, 1, 32'h1234_5000);
    queue_word(CMD_ALLOC, 1, 32'h0);
    queue_word(CMD_ALLOC, 1, 32'h0);
    wait_drained();
    held_runs.delete();

    run_phase(32'h0, 4096, 420);
    run_phase({20'($urandom_range(0, 32'hFFFFF)), 12'h000}, $urandom_range(1, 200), 300);
    run_phase(32'hFFFF_FFFF, 64, 200);
    run_phase($urandom, 8191, 300);
    run_phase($urandom, 0, 40);
    run_phase({20'($urandom_range(0, 32'hFFFFF)), 12'h000}, $urandom_range(100, 4096), 340);

    wait_drained();
    repeat (300) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS page_frame_bitmap_allocator_top");
    end else begin
      $display("FAIL page_frame_bitmap_allocator_top");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #(64'd30_000_000);
    $display("FAIL page_frame_bitmap_allocator_top");
    $finish;
  end

endmodule
